FILE: rtl/core/acf_pkg.sv
// shared constants, types and register codes for the allpass comb filter
// no dependencies; imported by every module in rtl/core
package acf_pkg;

    localparam int MAX_DELAY   = 1024;
    localparam int ADDR_W      = $clog2(MAX_DELAY);
    localparam int COUNT_W     = $clog2(MAX_DELAY + 1);
    localparam int SAMPLE_W    = 16;
    localparam int NARROW_W    = 8;
    localparam int GAIN_W      = 16;
    localparam int LEN_W       = 11;
    localparam int DIST_W      = (COUNT_W > LEN_W) ? COUNT_W : LEN_W;
    localparam int FRAC_W      = 15;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN         = 2'd0,
        REG_DELAY_LENGTH = 2'd1,
        REG_WIDE_SAMPLES = 2'd2
    } cfg_reg_t;

    // one history entry: stored input and stored output of the same step
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
    } hist_word_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        hist_word_t        data;
    } hist_wr_t;

    // sample handed to the datapath on acceptance
    typedef struct packed {
        logic                       valid;
        logic                       tap_valid;
        logic [ADDR_W-1:0]          wr_addr;
        logic signed [SAMPLE_W-1:0] x;
    } issue_t;

endpackage

FILE: rtl/core/allpass_comb_filter.sv
// top level of the allpass comb filter: config registers, sample control, output buffer
// depends on acf_pkg, acf_history and acf_datapath
//
// Schroeder allpass section, y = -g*x + x[n-M] + g*y[n-M], with g a signed Q1.15
// gain and M the delay_length register (0 acts as 1, values above 1024 act as 1024).
// Products are summed at full width, shifted right by 15 (rounding toward minus
// infinity) and saturated to 8 or 16 bits as wide_samples selects; 8-bit results come
// out sign-extended, and in 8-bit mode only the low byte of sample_in is used.
// A sample can follow the previous one once that one has left the first datapath
// stage: the past input and past output of a tap share one memory word, read when a
// sample is accepted and written back from the second datapath stage, so the next
// sample's tap read lands on the same edge as that write-back and is bypassed. A result
// passes the s1 and s2 datapath registers, then the two-entry output buffer, which lets
// one more sample enter while a result waits on out_stall; in_stall rises only while
// a sample is in the first datapath stage or both buffer slots are spoken for.
// History before the first sample reads as zero through a fill count, so there is no
// clearing pass after reset. Configuration writes are always ready and must only be
// issued while no sample is in flight.
module allpass_comb_filter import acf_pkg::*; (
    input  logic                         clk,
    input  logic                         rst_n,
    // sample input
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [SAMPLE_W-1:0]   sample_in,
    // sample output
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [SAMPLE_W-1:0]   sample_out,
    // configuration writes
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int OUT_DEPTH = 2;
    localparam int CREDIT_W  = $clog2(OUT_DEPTH + 1);
    localparam int OPTR_W    = $clog2(OUT_DEPTH);

    // configuration registers
    logic signed [GAIN_W-1:0] gain_reg;
    logic [LEN_W-1:0]         delay_length_reg;
    logic                     wide_samples_reg;

    // stream position and how many slots hold real history
    logic [ADDR_W-1:0]  wp_reg;
    logic [ADDR_W-1:0]  wp_next;
    logic [COUNT_W-1:0] fill_reg;
    logic [COUNT_W-1:0] fill_next;

    // samples in flight plus results buffered
    logic [CREDIT_W-1:0] credit_reg;
    logic [CREDIT_W-1:0] credit_next;

    // output buffer
    logic signed [SAMPLE_W-1:0] out_buf_reg [OUT_DEPTH];
    logic [OPTR_W-1:0]          out_wr_ptr_reg;
    logic [OPTR_W-1:0]          out_wr_ptr_next;
    logic [OPTR_W-1:0]          out_rd_ptr_reg;
    logic [OPTR_W-1:0]          out_rd_ptr_next;
    logic [CREDIT_W-1:0]        out_count_reg;
    logic [CREDIT_W-1:0]        out_count_next;

    logic                       accept;
    logic                       pop;
    logic                       busy;
    logic [DIST_W-1:0]          dist_raw;
    logic [DIST_W-1:0]          tap_dist;
    logic [DIST_W-1:0]          wp_ext;
    logic [DIST_W-1:0]          rd_ext;
    logic [ADDR_W-1:0]          rd_addr;
    logic signed [SAMPLE_W-1:0] x;
    issue_t                     issue;
    hist_word_t                 tap;
    hist_wr_t                   wr;
    logic                       result_valid;
    logic signed [SAMPLE_W-1:0] result_sample;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg         <= GAIN_W'(16384);
            delay_length_reg <= LEN_W'(1);
            wide_samples_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GAIN:         gain_reg         <= cfg_data[GAIN_W-1:0];
                REG_DELAY_LENGTH: delay_length_reg <= cfg_data[LEN_W-1:0];
                REG_WIDE_SAMPLES: wide_samples_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // new sample only when its tap read cannot collide with an older write-back
    assign in_stall  = busy || (credit_reg == CREDIT_W'(OUT_DEPTH));
    assign accept    = in_valid && !in_stall;
    assign out_valid = (out_count_reg != '0);
    assign pop       = out_valid && !out_stall;

    // effective delay, clamped to 1..MAX_DELAY
    always_comb
    begin
        dist_raw = DIST_W'(delay_length_reg);
        if (dist_raw == '0)
        begin
            tap_dist = DIST_W'(1);
        end
        else if (dist_raw > DIST_W'(MAX_DELAY))
        begin
            tap_dist = DIST_W'(MAX_DELAY);
        end
        else
        begin
            tap_dist = dist_raw;
        end
    end

    // circular tap address; a full-length delay reads the slot about to be reused
    always_comb
    begin
        wp_ext = DIST_W'(wp_reg);
        if (wp_ext >= tap_dist)
        begin
            rd_ext = wp_ext - tap_dist;
        end
        else
        begin
            rd_ext = wp_ext + (DIST_W'(MAX_DELAY) - tap_dist);
        end
        rd_addr = rd_ext[ADDR_W-1:0];
    end

    assign x = wide_samples_reg ? sample_in : SAMPLE_W'($signed(sample_in[NARROW_W-1:0]));

    assign issue.valid     = accept;
    assign issue.tap_valid = (tap_dist <= DIST_W'(fill_reg));
    assign issue.wr_addr   = wp_reg;
    assign issue.x         = x;

    always_comb
    begin
        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (accept)
        begin
            wp_next = (wp_reg == ADDR_W'(MAX_DELAY - 1)) ? '0 : wp_reg + 1'b1;
            if (fill_reg != COUNT_W'(MAX_DELAY))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        credit_next     = credit_reg + CREDIT_W'(accept) - CREDIT_W'(pop);
        out_count_next  = out_count_reg + CREDIT_W'(result_valid) - CREDIT_W'(pop);
        out_wr_ptr_next = out_wr_ptr_reg;
        out_rd_ptr_next = out_rd_ptr_reg;
        if (result_valid)
        begin
            out_wr_ptr_next = (out_wr_ptr_reg == OPTR_W'(OUT_DEPTH - 1)) ? '0
                                                                           : out_wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            out_rd_ptr_next = (out_rd_ptr_reg == OPTR_W'(OUT_DEPTH - 1)) ? '0
                                                                           : out_rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg         <= '0;
            fill_reg       <= '0;
            credit_reg     <= '0;
            out_count_reg  <= '0;
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
        end
        else
        begin
            wp_reg         <= wp_next;
            fill_reg       <= fill_next;
            credit_reg     <= credit_next;
            out_count_reg  <= out_count_next;
            out_wr_ptr_reg <= out_wr_ptr_next;
            out_rd_ptr_reg <= out_rd_ptr_next;
        end
    end

    // credits guarantee a free slot whenever a result arrives
    always_ff @(posedge clk)
    begin
        if (result_valid)
        begin
            out_buf_reg[out_wr_ptr_reg] <= result_sample;
        end
    end

    assign sample_out = out_buf_reg[out_rd_ptr_reg];

    acf_history u_history (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (tap),
        .wr      (wr)
    );

    acf_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .issue         (issue),
        .tap           (tap),
        .gain          (gain_reg),
        .wide          (wide_samples_reg),
        .busy          (busy),
        .wr            (wr),
        .result_valid  (result_valid),
        .result_sample (result_sample)
    );

endmodule

FILE: rtl/core/acf_history.sv
// combined input/output delay memory with registered read and write bypass
// depends on acf_pkg
module acf_history import acf_pkg::*; (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output hist_word_t        rd_data,
    input  hist_wr_t          wr
);

    hist_word_t mem [MAX_DELAY];
    hist_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // a read that meets the write-back of the same slot sees the new word
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr.en && (wr.addr == rd_addr))
            begin
                rd_data_reg <= wr.data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/acf_datapath.sv
// two-stage arithmetic: gain multiply, then sum, shift and saturation
// depends on acf_pkg; takes taps from acf_history and writes back into it
module acf_datapath import acf_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  issue_t                     issue,
    input  hist_word_t                 tap,
    input  logic signed [GAIN_W-1:0]   gain,
    input  logic                       wide,
    output logic                       busy,
    output hist_wr_t                   wr,
    output logic                       result_valid,
    output logic signed [SAMPLE_W-1:0] result_sample
);

    localparam int PROD_W = GAIN_W + SAMPLE_W + 1;
    localparam int ACC_W  = PROD_W + 1;
    localparam int Y_W    = ACC_W - FRAC_W;

    localparam logic signed [Y_W-1:0] WIDE_HI   = Y_W'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic signed [Y_W-1:0] WIDE_LO   = -Y_W'(2 ** (SAMPLE_W - 1));
    localparam logic signed [Y_W-1:0] NARROW_HI = Y_W'(2 ** (NARROW_W - 1) - 1);
    localparam logic signed [Y_W-1:0] NARROW_LO = -Y_W'(2 ** (NARROW_W - 1));

    logic                       s1_valid_reg;
    logic                       s1_tap_valid_reg;
    logic [ADDR_W-1:0]          s1_addr_reg;
    logic signed [SAMPLE_W-1:0] s1_x_reg;

    logic                       s2_valid_reg;
    logic [ADDR_W-1:0]          s2_addr_reg;
    logic signed [SAMPLE_W-1:0] s2_x_reg;
    logic signed [SAMPLE_W-1:0] s2_xd_reg;
    logic signed [PROD_W-1:0]   s2_prod_reg;

    logic signed [SAMPLE_W-1:0] xd;
    logic signed [SAMPLE_W-1:0] yd;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]    acc;
    logic signed [Y_W-1:0]      y_full;
    logic signed [Y_W-1:0]      y_hi;
    logic signed [Y_W-1:0]      y_lo;
    logic signed [Y_W-1:0]      y_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue.valid)
        begin
            s1_tap_valid_reg <= issue.tap_valid;
            s1_addr_reg      <= issue.wr_addr;
            s1_x_reg         <= issue.x;
        end
        if (s1_valid_reg)
        begin
            s2_addr_reg <= s1_addr_reg;
            s2_x_reg    <= s1_x_reg;
            s2_xd_reg   <= xd;
            s2_prod_reg <= prod_next;
        end
    end

    // history never written reads as zero
    always_comb
    begin
        xd        = s1_tap_valid_reg ? tap.x : '0;
        yd        = s1_tap_valid_reg ? tap.y : '0;
        diff      = (SAMPLE_W + 1)'(yd) - (SAMPLE_W + 1)'(s1_x_reg);
        prod_next = gain * diff;
    end

    always_comb
    begin
        acc    = ACC_W'(s2_prod_reg) + (ACC_W'(s2_xd_reg) <<< FRAC_W);
        y_full = acc[ACC_W-1:FRAC_W];
        y_hi   = wide ? WIDE_HI : NARROW_HI;
        y_lo   = wide ? WIDE_LO : NARROW_LO;
        if (y_full > y_hi)
        begin
            y_sat = y_hi;
        end
        else if (y_full < y_lo)
        begin
            y_sat = y_lo;
        end
        else
        begin
            y_sat = y_full;
        end
    end

    assign busy          = s1_valid_reg;
    assign wr.en         = s2_valid_reg;
    assign wr.addr       = s2_addr_reg;
    assign wr.data.x     = s2_x_reg;
    assign wr.data.y     = SAMPLE_W'(y_sat);
    assign result_valid  = s2_valid_reg;
    assign result_sample = SAMPLE_W'(y_sat);

endmodule

FILE: bench/tb.sv
// self-checking bench for allpass_comb_filter: directed corners, then randomized streams
// depends on acf_pkg and the rtl/core sources; predicts every sample in place
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import acf_pkg::*;

    // run length guard, well above the slowest legal run
    localparam int CYCLE_LIMIT = 250000;
    // index with no register behind it, writes to it are ignored
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    // filter state as the bench sees it
    logic signed [SAMPLE_W-1:0] past_inputs  [0:MAX_DELAY-1];
    logic signed [SAMPLE_W-1:0] past_outputs [0:MAX_DELAY-1];
    int unsigned                slot;
    logic signed [GAIN_W-1:0]   coef;
    logic [LEN_W-1:0]           taps_reg;
    logic                       wide_mode;

    // predicted samples, oldest first
    logic signed [SAMPLE_W-1:0] expected_samples [$];
    int                         mismatch_count = 0;
    int                         result_count   = 0;
    int                         cycle_count    = 0;
    // when set, neither side inserts idle cycles
    logic                       no_idle;

    allpass_comb_filter u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // one allpass step: y = (g*(y[n-M] - x) + 2^15*x[n-M]) >>> 15, then saturate
    function automatic logic signed [SAMPLE_W-1:0] filter_step(
        input logic signed [SAMPLE_W-1:0] raw);
        int unsigned tap_dist;
        int unsigned rd;
        longint      x;
        longint      xd;
        longint      yd;
        longint      acc;
        longint      y;
        longint      lo;
        longint      hi;
        // zero acts as one, anything past the memory depth clips to it
        tap_dist = taps_reg;
        if (tap_dist == 0)
            tap_dist = 1;
        if (tap_dist > MAX_DELAY)
            tap_dist = MAX_DELAY;
        // narrow mode keeps only the low byte, sign extended
        if (wide_mode)
            x = longint'(raw);
        else
            x = longint'($signed(raw[NARROW_W-1:0]));
        rd  = (slot + MAX_DELAY - tap_dist) % MAX_DELAY;
        xd  = past_inputs[rd];
        yd  = past_outputs[rd];
        acc = longint'(coef) * (yd - x) + xd * 32768;
        // arithmetic shift floors toward minus infinity
        y   = acc >>> FRAC_W;
        lo  = wide_mode ? -32768 : -128;
        hi  = wide_mode ? 32767 : 127;
        if (y < lo)
            y = lo;
        if (y > hi)
            y = hi;
        past_inputs[slot]  = x[SAMPLE_W-1:0];
        past_outputs[slot] = y[SAMPLE_W-1:0];
        slot = (slot + 1) % MAX_DELAY;
        return y[SAMPLE_W-1:0];
    endfunction

    // block until every predicted sample has come out
    task automatic wait_idle();
        while (expected_samples.size() != 0)
            @(posedge clk);
    endtask

    // one sample transaction, with a random lead-in gap
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= value;
        // accepted on the first edge without stall
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        expected_samples.push_back(filter_step(value));
    endtask

    // register write, only once the pipeline has drained
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        in_valid <= 1'b0;
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (idx)
            REG_GAIN:         coef      = data;
            REG_DELAY_LENGTH: taps_reg  = data[LEN_W-1:0];
            REG_WIDE_SAMPLES: wide_mode = data[0];
            default:          ;
        endcase
    endtask

    // random sample, biased toward corners and toward the active width
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (!wide_mode && r < 8)
            return SAMPLE_W'($signed(NARROW_W'($urandom())));
        case (r)
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return SAMPLE_W'($urandom_range(0, 255)) - 16'sd128;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // reset values with empty history, including both sample extremes
    task automatic test_default_settings();
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(-16'sd1);
        send_sample(16'sd0);
        send_sample(16'sd1);
    endtask

    // full-scale gains push the sum past the sample range
    task automatic test_gain_extremes();
        write_register(REG_GAIN, 16'h8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        write_register(REG_GAIN, 16'h7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        write_register(REG_GAIN, 16'h0000);
        send_sample(16'sd12345);
        send_sample(-16'sd1);
    endtask

    // 8-bit mode: upper byte ignored, values wrap, output clips to a byte
    task automatic test_narrow_samples();
        write_register(REG_GAIN, 16'hC000);
        write_register(REG_WIDE_SAMPLES, 16'hFFFE);
        send_sample(16'sh7F80);
        send_sample(16'sh00FF);
        send_sample(16'sd127);
        send_sample(-16'sd128);
        send_sample(16'sh0080);
    endtask

    // delay zero, delay above depth, full depth on empty history, ignored index
    task automatic test_delay_edges();
        write_register(REG_WIDE_SAMPLES, 16'h0001);
        write_register(REG_DELAY_LENGTH, 16'h0000);
        send_sample(16'sh4000);
        send_sample(16'sh8000);
        write_register(REG_DELAY_LENGTH, 16'hFFFF);
        send_sample(16'sd300);
        send_sample(-16'sd300);
        write_register(REG_DELAY_LENGTH, 16'd1024);
        send_sample(16'sh7FFF);
        send_sample(16'sd7);
        write_register(REG_UNUSED, 16'($urandom()));
        write_register(REG_DELAY_LENGTH, 16'd1);
        send_sample(16'sd1000);
    endtask

    // several settings in turn, history carried across every change
    task automatic test_random_settings();
        int               r;
        logic [LEN_W-1:0] len;
        logic [15:0]      word;
        for (int phase = 0; phase < 16; phase++)
        begin
            // gain, extremes in the first phases
            if (phase == 0)
                word = 16'h8000;
            else if (phase == 1)
                word = 16'h7FFF;
            else if (phase == 2)
                word = 16'h0000;
            else
                word = 16'($urandom());
            write_register(REG_GAIN, word);
            // delay, mostly short so the taps see real history quickly
            r = $urandom_range(0, 9);
            case (r)
                0:       len = 11'd0;
                1:       len = 11'($urandom_range(1025, 2047));
                2:       len = 11'($urandom_range(100, 1024));
                default: len = 11'($urandom_range(1, 24));
            endcase
            word = 16'($urandom());
            word[LEN_W-1:0] = len;
            write_register(REG_DELAY_LENGTH, word);
            write_register(REG_WIDE_SAMPLES, 16'($urandom()));
            no_idle = (phase % 4 == 3);
            repeat (62) send_sample(pick_sample());
            no_idle = 1'b0;
        end
    endtask

    // delay at full depth once the memories have wrapped, then mode and clip changes
    task automatic test_full_length();
        write_register(REG_GAIN, 16'($urandom()));
        write_register(REG_WIDE_SAMPLES, 16'h0001);
        write_register(REG_DELAY_LENGTH, 16'd1024);
        no_idle = 1'b1;
        repeat (160) send_sample(pick_sample());
        no_idle = 1'b0;
        repeat (160) send_sample(pick_sample());
        // mode flip mid-stream, taps still read full stored width
        write_register(REG_WIDE_SAMPLES, 16'h0000);
        repeat (160) send_sample(pick_sample());
        write_register(REG_WIDE_SAMPLES, 16'h0001);
        write_register(REG_DELAY_LENGTH, 16'h07FF);
        repeat (160) send_sample(pick_sample());
    endtask

    // result side: random stall after each transaction, compare with oldest prediction
    initial
    begin : result_checker
        int                         stall_left;
        logic signed [SAMPLE_W-1:0] want;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                result_count++;
                if (expected_samples.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d: none expected, got %0d",
                                 result_count, sample_out);
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample_out !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result %0d: sample_out expected %0d, got %0d",
                                     result_count, want, sample_out);
                    end
                end
                stall_left = no_idle ? 0 : $urandom_range(0, 9);
            end
            // one assignment per edge
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // hang guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        // known values on every input from time zero
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        sample_in = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        no_idle   = 1'b0;
        // predictor at its reset state
        coef      = 16'sd16384;
        taps_reg  = 11'd1;
        wide_mode = 1'b1;
        slot      = 0;
        for (int i = 0; i < MAX_DELAY; i++)
        begin
            past_inputs[i]  = '0;
            past_outputs[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_settings();
        test_gain_extremes();
        test_narrow_samples();
        test_delay_edges();
        test_random_settings();
        test_full_length();

        // drain, then wait for any stray transaction
        in_valid <= 1'b0;
        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_samples.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/acf_pkg.sv
rtl/core/acf_history.sv
rtl/core/acf_datapath.sv
rtl/core/allpass_comb_filter.sv
bench/tb.sv
